// ===== design/rtscf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtscf_pkg
// Shared types, constants and helper functions for the RTTY sentence framer.
// ----------------------------------------------------------------------------
package rtscf_pkg;

  // Framing of one character on the air
  localparam int DATA_BITS     = 7;
  localparam int STOP_BITS     = 2;
  localparam int SYMS_PER_CHAR = 1 + DATA_BITS + STOP_BITS;
  localparam int SYM_W         = $clog2(SYMS_PER_CHAR);
  localparam int DIDX_W        = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

  // Trailer: star plus four hex digits
  localparam int TRAILER_CHARS = 5;
  localparam int CHAR_IDX_W    = 3;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  STAR_CHAR = 8'h2A;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CRC_SKIP    = 3'd0,
    REG_CRC_SEED    = 3'd1,
    REG_MARK_LEVEL  = 3'd2,
    REG_SPACE_LEVEL = 3'd3,
    REG_APPEND_CRC  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  crc_skip;
    logic [15:0] crc_seed;
    logic [7:0]  mark_level;
    logic [7:0]  space_level;
    logic        append_crc;
  } cfg_t;

  // One queued sentence character with what the back end needs to send it
  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic                 last;
    logic                 trailer;
    logic [15:0]          crc;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Uppercase ASCII hex digit
  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) r = 8'h30 + {4'h0, v};
    else           r = 8'h37 + {4'h0, v};
    return r;
  endfunction

endpackage

// ===== design/rtty_sentence_crc_framer_core.sv =====
// ----------------------------------------------------------------------------
// rtty_sentence_crc_framer_core
// RTTY framer for telemetry sentences with a CRC-16 hex trailer.
// ----------------------------------------------------------------------------
// Input channel: one sentence byte per word (data_byte, sentence_end), taken
// when in_valid is high and in_stall is low. Output channel: one RTTY symbol
// per word (tone_bit, drive_level, run_last, frame_done), taken when
// out_valid is high and out_stall is low.
// Every byte becomes ten symbols: a start space, seven data bits LSB first
// and two stop marks. When sentence_end is set and append_crc is 1, a star
// and four uppercase hex CRC digits follow, 60 symbols in all for that byte.
// An accepted byte passes through the queue and the current-word register
// before its first symbol is registered at the output. The symbol
// serializer emits one symbol per cycle while the output is not stalled.
// A four-word queue between the CRC front end and the serializer lets a few
// bytes be accepted ahead; in_stall rises only when that queue is full.
// A stalled output holds its symbol and the serializer waits behind it.
// Reset clears the queue, the output register and the byte position, loads
// FFFF into the CRC, and sets the registers to their defaults. Configuration
// writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module rtty_sentence_crc_framer_core
  import rtscf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        sentence_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tone_bit,
  output logic [7:0]  drive_level,
  output logic        run_last,
  output logic        frame_done
);

  cfg_t     cfg;
  q_push_t  q_push;
  q_stat_t  q_stat;
  q_entry_t head;
  logic     pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_skip    <= 4'd2;
      cfg.crc_seed    <= 16'hFFFF;
      cfg.mark_level  <= 8'd110;
      cfg.space_level <= 8'd100;
      cfg.append_crc  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CRC_SKIP:    cfg.crc_skip    <= cfg_data[3:0];
        REG_CRC_SEED:    cfg.crc_seed    <= cfg_data;
        REG_MARK_LEVEL:  cfg.mark_level  <= cfg_data[7:0];
        REG_SPACE_LEVEL: cfg.space_level <= cfg_data[7:0];
        REG_APPEND_CRC:  cfg.append_crc  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rtscf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .sentence_end (sentence_end),
    .q_stat       (q_stat),
    .q_push       (q_push)
  );

  rtscf_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  rtscf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tone_bit    (tone_bit),
    .drive_level (drive_level),
    .run_last    (run_last),
    .frame_done  (frame_done)
  );

endmodule

// ===== design/rtscf_front.sv =====
// ----------------------------------------------------------------------------
// rtscf_front
// Accepts sentence bytes, runs the CRC and byte position, queues each word.
// ----------------------------------------------------------------------------
module rtscf_front
  import rtscf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       sentence_end,
  input  q_stat_t    q_stat,
  output q_push_t    q_push
);

  logic [15:0] crc_reg;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [3:0]  byte_position;
  logic        accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Reload the seed at the first position, then fold in bytes past the skip count
  always_comb begin
    crc_base = (byte_position == 4'd0) ? cfg.crc_seed : crc_reg;
    crc_next = (byte_position >= cfg.crc_skip) ? crc16_byte(crc_base, data_byte)
                                               : crc_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg       <= 16'hFFFF;
      byte_position <= 4'd0;
    end else if (accept) begin
      if (sentence_end) begin
        crc_reg       <= cfg.crc_seed;
        byte_position <= 4'd0;
      end else begin
        crc_reg <= crc_next;
        if (byte_position != 4'd15) byte_position <= byte_position + 4'd1;
      end
    end
  end

  // Hand the word to the queue
  always_comb begin
    q_push.valid         = accept;
    q_push.entry.data    = data_byte[DATA_BITS-1:0];
    q_push.entry.last    = sentence_end;
    q_push.entry.trailer = sentence_end && cfg.append_crc;
    q_push.entry.crc     = crc_next;
  end

endmodule

// ===== design/rtscf_fifo.sv =====
// ----------------------------------------------------------------------------
// rtscf_fifo
// Short queue of pending characters between the front and back ends.
// ----------------------------------------------------------------------------
module rtscf_fifo
  import rtscf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_push_t  q_push,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  q_entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = q_push.valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= q_push.entry;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop)      count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ===== design/rtscf_back.sv =====
// ----------------------------------------------------------------------------
// rtscf_back
// Serializes queued characters and the CRC trailer into RTTY symbols.
// ----------------------------------------------------------------------------
module rtscf_back
  import rtscf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  q_entry_t   head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tone_bit,
  output logic [7:0] drive_level,
  output logic       run_last,
  output logic       frame_done
);

  q_entry_t              cur;
  logic                  cur_valid;
  logic [CHAR_IDX_W-1:0] char_idx;
  logic [SYM_W-1:0]      sym_idx;

  logic [7:0]            ch;
  logic [SYM_W-1:0]      bit_pos;
  logic                  sym_bit;
  logic                  char_end;
  logic                  item_end;
  logic                  advance;

  // Pick the character being sent: the data byte, the star, then hex digits
  always_comb begin
    unique case (char_idx)
      3'd0:    ch = {{(8-DATA_BITS){1'b0}}, cur.data};
      3'd1:    ch = STAR_CHAR;
      3'd2:    ch = hex_ascii(cur.crc[15:12]);
      3'd3:    ch = hex_ascii(cur.crc[11:8]);
      3'd4:    ch = hex_ascii(cur.crc[7:4]);
      default: ch = hex_ascii(cur.crc[3:0]);
    endcase
  end

  // Start space, data bits LSB first, then stop marks
  always_comb begin
    bit_pos = sym_idx - SYM_W'(1);
    if (sym_idx == '0)                       sym_bit = 1'b0;
    else if (sym_idx <= SYM_W'(DATA_BITS))   sym_bit = ch[bit_pos[DIDX_W-1:0]];
    else                                     sym_bit = 1'b1;
  end

  assign char_end = (sym_idx == SYM_W'(SYMS_PER_CHAR - 1));
  assign item_end = char_end &&
                    (char_idx == (cur.trailer ? CHAR_IDX_W'(TRAILER_CHARS) : '0));
  assign advance  = cur_valid && (!out_valid || !out_stall);
  assign pop      = !q_stat.empty && (!cur_valid || (advance && item_end));

  // Load the next word from the queue
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  // Walk symbols and characters of the current word
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      char_idx  <= '0;
      sym_idx   <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      char_idx  <= '0;
      sym_idx   <= '0;
    end else if (advance) begin
      if (item_end) begin
        cur_valid <= 1'b0;
      end else if (char_end) begin
        sym_idx  <= '0;
        char_idx <= char_idx + CHAR_IDX_W'(1);
      end else begin
        sym_idx <= sym_idx + SYM_W'(1);
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tone_bit    <= sym_bit;
      drive_level <= sym_bit ? cfg.mark_level : cfg.space_level;
      run_last    <= item_end;
      frame_done  <= item_end && cur.last;
    end
  end

endmodule

// ===== design/rtscf_checker.sv =====
// ----------------------------------------------------------------------------
// rtscf_checker
// Port-level checks on the framer's symbol stream.
// ----------------------------------------------------------------------------
module rtscf_checker
  import rtscf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       tone_bit,
  input logic [7:0] drive_level,
  input logic       run_last,
  input logic       frame_done
);

  // Output register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("symbol shown right after reset");

  // A stalled symbol holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_bit) &&
      $stable(drive_level) && $stable(run_last) && $stable(frame_done))
    else $error("stalled symbol changed");

  // End of sentence is always the end of a word's run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

  // A run always ends on a stop mark
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_last |-> tone_bit)
    else $error("run ended on a space symbol");

endmodule

bind rtty_sentence_crc_framer_core rtscf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .tone_bit    (tone_bit),
  .drive_level (drive_level),
  .run_last    (run_last),
  .frame_done  (frame_done)
);
